// ----- hw/rtl/rlit_pkg.sv -----
package rlit_pkg;

  // Table geometry.
  localparam int SLOTS   = 64;
  localparam int IDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W   = $clog2(SLOTS + 1);

  localparam int TAG_W   = 32;
  localparam int REFS_W  = 16;
  localparam int GEN_W   = 16;
  localparam int STAMP_W = 32;
  localparam int SIDX_W  = 6;

  localparam logic [REFS_W-1:0] REFS_MAX = {REFS_W{1'b1}};

  typedef enum logic [1:0] {
    OP_LOOKUP  = 2'd0,
    OP_ACQUIRE = 2'd1,
    OP_RELEASE = 2'd2,
    OP_FORGET  = 2'd3
  } rlit_op_t;

  typedef enum logic [2:0] {
    ST_HIT       = 3'd0,
    ST_NEW       = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_INVALID   = 3'd3,
    ST_FULL      = 3'd4
  } rlit_status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE
  } rlit_state_t;

  typedef struct packed {
    logic [TAG_W-1:0]   tag;
    logic [REFS_W-1:0]  refs;
    logic [GEN_W-1:0]   gen;
    logic [STAMP_W-1:0] stamp;
  } rlit_entry_t;

  localparam int ENTRY_W = $bits(rlit_entry_t);

  // Outcome of one pass over the table.
  typedef struct packed {
    logic              hit;
    logic [IDX_W-1:0]  hit_idx;
    rlit_entry_t       hit_ent;
    logic              empty_found;
    logic [IDX_W-1:0]  empty_idx;
    logic              cand_found;
    logic [IDX_W-1:0]  cand_idx;
  } rlit_scan_t;

endpackage

// ----- hw/rtl/rlit_ram.sv -----
module rlit_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hw/rtl/rlit_scan.sv -----
module rlit_scan
  import rlit_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              clear,
  input  logic              ent_vld,
  input  logic [IDX_W-1:0]  ent_idx,
  input  logic              ent_used,
  input  rlit_entry_t       ent,
  input  logic [TAG_W-1:0]  key,
  output rlit_scan_t        res
);

  rlit_scan_t         res_r, res_nxt;
  logic [STAMP_W-1:0] cand_stamp_r, cand_stamp_nxt;

  // First matching tag, first empty slot, and the oldest unreferenced slot
  // (strictly smaller stamp replaces, so the lower index keeps a tie).
  always_comb begin
    res_nxt        = res_r;
    cand_stamp_nxt = cand_stamp_r;
    if (clear) begin
      res_nxt        = '0;
      cand_stamp_nxt = '0;
    end else if (ent_vld) begin
      if (ent_used && (ent.tag == key) && !res_r.hit) begin
        res_nxt.hit     = 1'b1;
        res_nxt.hit_idx = ent_idx;
        res_nxt.hit_ent = ent;
      end
      if (!ent_used && !res_r.empty_found) begin
        res_nxt.empty_found = 1'b1;
        res_nxt.empty_idx   = ent_idx;
      end
      if (ent_used && (ent.refs == '0) &&
          (!res_r.cand_found || (ent.stamp < cand_stamp_r))) begin
        res_nxt.cand_found = 1'b1;
        res_nxt.cand_idx   = ent_idx;
        cand_stamp_nxt     = ent.stamp;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r        <= '0;
      cand_stamp_r <= '0;
    end else begin
      res_r        <= res_nxt;
      cand_stamp_r <= cand_stamp_nxt;
    end
  end

  assign res = res_r;

endmodule

// ----- hw/rtl/refcounted_lru_inode_table_unit.sv -----
// Reference-counted LRU inode table. A request is taken when start is high
// and busy is low; it names an operation (lookup, acquire, release or
// forget) and an inode tag. Every request gives exactly one result, shown on
// the out_ ports for a single cycle while out_valid is high; the receiver
// cannot hold it off, so it must capture the item in that cycle. A request
// with a nonzero tag reads every slot of the table memory in turn through its
// single read port, one slot per cycle, then decides and writes back at most
// one slot: busy stays high through the sweep and the decision, and the
// result appears in the same cycle that busy falls, so a new request can
// only be taken once the last one is through. A request with a zero tag is
// answered at once with the invalid-tag status: its result appears in the
// next cycle and busy never rises. The table comes out of reset empty, with
// no clearing pass, as each slot carries a valid flag held in flip-flops.
module refcounted_lru_inode_table_unit
  import rlit_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          in_op,
  input  logic [TAG_W-1:0]    in_inode_number,
  output logic                out_valid,
  output logic [2:0]          out_status,
  output logic [SIDX_W-1:0]   out_slot_index,
  output logic [REFS_W-1:0]   out_ref_count,
  output logic [GEN_W-1:0]    out_generation_out,
  output logic [STAMP_W-1:0]  out_use_stamp_out
);

  rlit_state_t state_r, state_nxt;

  logic               accept;
  logic               zero_tag;

  // Latched request.
  rlit_op_t           op_r;
  logic [TAG_W-1:0]   tag_r;

  // Global counters of the table.
  logic [GEN_W-1:0]   next_gen_r;
  logic [STAMP_W-1:0] use_clock_r;

  // Per-slot valid flags: a slot that is not valid reads as all zero.
  logic [SLOTS-1:0]   slot_vld_r;

  // Read sweep: issue counter, and the slot whose data the memory is returning.
  logic [CNT_W-1:0]   rd_cnt_r;
  logic               rd_pend_r;
  logic [IDX_W-1:0]   rd_idx_r;
  logic               slot_vld_rd_r;
  logic               ram_re;
  logic [IDX_W-1:0]   ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;
  rlit_entry_t        rd_ent;
  logic               last_rd;

  logic               scan_clr;
  logic               decide;
  rlit_scan_t         scan;

  // Decision for the current request.
  logic               wr_en;
  logic [IDX_W-1:0]   wr_idx;
  rlit_entry_t        wr_ent;
  rlit_status_t       res_status;
  logic [IDX_W-1:0]   res_idx;
  rlit_entry_t        res_ent;
  logic               set_vld;
  logic               clr_vld;
  logic               adv_clk;
  logic               adv_gen;
  logic [STAMP_W-1:0] clk_inc;
  logic [IDX_W-1:0]   vic_idx;
  logic [IDX_W+SIDX_W-1:0] idx_ext;

  logic               out_valid_r;
  logic [2:0]         out_status_r;
  logic [SIDX_W-1:0]  out_slot_index_r;
  logic [REFS_W-1:0]  out_ref_count_r;
  logic [GEN_W-1:0]   out_generation_r;
  logic [STAMP_W-1:0] out_use_stamp_r;

  assign busy     = (state_r != S_IDLE);
  assign accept   = start && !busy;
  assign zero_tag = (in_inode_number == '0);

  // -------------------------------------------------------------------------
  // Control sequencer
  // -------------------------------------------------------------------------
  assign last_rd = rd_pend_r && (rd_idx_r == IDX_W'(SLOTS - 1));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept && !zero_tag) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (last_rd) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    ram_re   = 1'b0;
    scan_clr = 1'b0;
    decide   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        scan_clr = accept;
      end
      S_SCAN: begin
        ram_re = (rd_cnt_r < CNT_W'(SLOTS));
      end
      S_DECIDE: begin
        decide = 1'b1;
      end
      default: begin
        ram_re = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // -------------------------------------------------------------------------
  // Table memory and the read sweep
  // -------------------------------------------------------------------------
  assign ram_raddr = rd_cnt_r[IDX_W-1:0];

  rlit_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOTS),
    .AW    (IDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_idx),
    .wdata (wr_ent),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_cnt_r  <= '0;
      rd_pend_r <= 1'b0;
    end else begin
      if (accept) begin
        rd_cnt_r <= '0;
      end else if (ram_re) begin
        rd_cnt_r <= rd_cnt_r + 1'b1;
      end
      rd_pend_r <= ram_re;
    end
  end

  always_ff @(posedge clk) begin
    if (ram_re) begin
      rd_idx_r      <= ram_raddr;
      slot_vld_rd_r <= slot_vld_r[ram_raddr];
    end
  end

  // Never-written or forgotten slots are masked to an empty entry.
  assign rd_ent = slot_vld_rd_r ? rlit_entry_t'(ram_rdata) : '0;

  rlit_scan u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .clear    (scan_clr),
    .ent_vld  (rd_pend_r),
    .ent_idx  (rd_idx_r),
    .ent_used (slot_vld_rd_r),
    .ent      (rd_ent),
    .key      (tag_r),
    .res      (scan)
  );

  // -------------------------------------------------------------------------
  // Decision and write-back. At most one slot is written per request, after the sweep
  // has finished, so reads and writes of the same slot cannot overlap.
  // -------------------------------------------------------------------------
  assign clk_inc = use_clock_r + 1'b1;
  assign vic_idx = scan.empty_found ? scan.empty_idx : scan.cand_idx;

  always_comb begin
    wr_en      = 1'b0;
    wr_idx     = scan.hit_idx;
    wr_ent     = scan.hit_ent;
    res_status = ST_NOT_FOUND;
    res_idx    = '0;
    res_ent    = '0;
    set_vld    = 1'b0;
    clr_vld    = 1'b0;
    adv_clk    = 1'b0;
    adv_gen    = 1'b0;
    case (op_r)
      OP_LOOKUP: begin
        if (scan.hit) begin
          res_status = ST_HIT;
          res_idx    = scan.hit_idx;
          res_ent    = scan.hit_ent;
        end
      end
      OP_ACQUIRE: begin
        if (scan.hit) begin
          if (scan.hit_ent.refs != REFS_MAX) begin
            wr_ent.refs = scan.hit_ent.refs + 1'b1;
          end
          wr_ent.stamp = clk_inc;
          wr_en        = decide;
          adv_clk      = decide;
          res_status   = ST_HIT;
          res_idx      = scan.hit_idx;
          res_ent      = wr_ent;
        end else if (scan.empty_found || scan.cand_found) begin
          wr_idx       = vic_idx;
          wr_ent.tag   = tag_r;
          wr_ent.refs  = REFS_W'(1);
          wr_ent.gen   = (next_gen_r == '0) ? GEN_W'(1) : next_gen_r;
          wr_ent.stamp = clk_inc;
          wr_en        = decide;
          set_vld      = decide;
          adv_clk      = decide;
          adv_gen      = decide;
          res_status   = ST_NEW;
          res_idx      = vic_idx;
          res_ent      = wr_ent;
        end else begin
          res_status = ST_FULL;
        end
      end
      OP_RELEASE: begin
        if (scan.hit) begin
          if (scan.hit_ent.refs != '0) begin
            wr_ent.refs = scan.hit_ent.refs - 1'b1;
          end
          wr_ent.stamp = clk_inc;
          wr_en        = decide;
          adv_clk      = decide;
          res_status   = ST_HIT;
          res_idx      = scan.hit_idx;
          res_ent      = wr_ent;
        end
      end
      OP_FORGET: begin
        if (scan.hit) begin
          clr_vld    = decide;
          res_status = ST_HIT;
          res_idx    = scan.hit_idx;
        end
      end
      default: begin
        res_status = ST_NOT_FOUND;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= rlit_op_t'(in_op);
      tag_r <= in_inode_number;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_vld_r  <= '0;
      next_gen_r  <= GEN_W'(1);
      use_clock_r <= '0;
    end else begin
      if (set_vld) begin
        slot_vld_r[wr_idx] <= 1'b1;
      end
      if (clr_vld) begin
        slot_vld_r[scan.hit_idx] <= 1'b0;
      end
      if (adv_gen) begin
        next_gen_r <= next_gen_r + 1'b1;
      end
      if (adv_clk) begin
        use_clock_r <= clk_inc;
      end
    end
  end

  // -------------------------------------------------------------------------
  // Result register: one item per strobe, held for a single cycle.
  // -------------------------------------------------------------------------
  assign idx_ext = {{SIDX_W{1'b0}}, res_idx};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (accept && zero_tag) || decide;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && zero_tag) begin
      out_status_r     <= ST_INVALID;
      out_slot_index_r <= '0;
      out_ref_count_r  <= '0;
      out_generation_r <= '0;
      out_use_stamp_r  <= '0;
    end else if (decide) begin
      out_status_r     <= res_status;
      out_slot_index_r <= idx_ext[SIDX_W-1:0];
      out_ref_count_r  <= res_ent.refs;
      out_generation_r <= res_ent.gen;
      out_use_stamp_r  <= res_ent.stamp;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_slot_index     = out_slot_index_r;
  assign out_ref_count      = out_ref_count_r;
  assign out_generation_out = out_generation_r;
  assign out_use_stamp_out  = out_use_stamp_r;

`ifndef SYNTHESIS
  // Every finished sweep produces a result in the following cycle.
  a_decide_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DECIDE) |=> out_valid)
    else $error("sweep finished without a result");

  // Read data only arrives while a sweep is in progress.
  a_read_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    rd_pend_r |-> (state_r == S_SCAN))
    else $error("table read outside a sweep");

  // A new entry always starts with one reference and a nonzero generation.
  a_new_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_NEW)) |->
      ((out_ref_count == REFS_W'(1)) && (out_generation_out != '0)))
    else $error("malformed new entry");
`endif

endmodule

// ----- tb/inode_table_checker.sv -----
`timescale 1ns / 1ps

module inode_table_checker
  import rlit_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  logic [1:0]         in_op,
  input  logic [TAG_W-1:0]   in_inode_number,
  input  logic               out_valid,
  input  logic [2:0]         out_status,
  input  logic [SIDX_W-1:0]  out_slot_index,
  input  logic [REFS_W-1:0]  out_ref_count,
  input  logic [GEN_W-1:0]   out_generation_out,
  input  logic [STAMP_W-1:0] out_use_stamp_out,
  output int                 fail_count,
  output int                 pending
);

  typedef struct packed {
    rlit_status_t       status;
    logic [SIDX_W-1:0]  slot;
    logic [REFS_W-1:0]  refs;
    logic [GEN_W-1:0]   gen;
    logic [STAMP_W-1:0] stamp;
  } inode_reply_t;

  // Shadow copy of the table.
  logic [TAG_W-1:0]   tag_of   [SLOTS];
  logic [REFS_W-1:0]  refs_of  [SLOTS];
  logic [GEN_W-1:0]   gen_of   [SLOTS];
  logic [STAMP_W-1:0] stamp_of [SLOTS];
  logic [GEN_W-1:0]   gen_next;
  logic [STAMP_W-1:0] use_clock_now;

  inode_reply_t replies_due[$];
  int           mismatches = 0;

  function automatic inode_reply_t slot_reply(input rlit_status_t st, input int idx);
    inode_reply_t r;
    r.status = st;
    r.slot   = SIDX_W'(idx);
    r.refs   = refs_of[idx];
    r.gen    = gen_of[idx];
    r.stamp  = stamp_of[idx];
    return r;
  endfunction

  // Applies one request to the shadow table and returns the reply it should give.
  function automatic inode_reply_t predict_reply(input rlit_op_t op,
                                                 input logic [TAG_W-1:0] ino);
    int           hit;
    int           victim;
    bit           empty_seen;
    inode_reply_t r;
    r = '0;
    if (ino == '0) begin
      r.status = ST_INVALID;
      return r;
    end
    hit = -1;
    for (int i = 0; i < SLOTS; i++) begin
      if (hit < 0 && tag_of[i] == ino) hit = i;
    end

    if (op == OP_ACQUIRE) begin
      if (hit >= 0) begin
        if (refs_of[hit] != REFS_MAX) refs_of[hit] = refs_of[hit] + 1'b1;
        use_clock_now = use_clock_now + 1'b1;
        stamp_of[hit] = use_clock_now;
        return slot_reply(ST_HIT, hit);
      end
      // The first empty slot wins outright; otherwise the oldest unreferenced one.
      victim = -1;
      empty_seen = 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        if (!empty_seen) begin
          if (tag_of[i] == '0) begin
            victim = i;
            empty_seen = 1'b1;
          end else if (refs_of[i] == '0 &&
                       (victim < 0 || stamp_of[i] < stamp_of[victim])) begin
            victim = i;
          end
        end
      end
      if (victim < 0) begin
        r.status = ST_FULL;
        return r;
      end
      tag_of[victim]  = ino;
      refs_of[victim] = REFS_W'(1);
      gen_of[victim]  = (gen_next == '0) ? GEN_W'(1) : gen_next;
      gen_next        = gen_next + 1'b1;
      use_clock_now   = use_clock_now + 1'b1;
      stamp_of[victim] = use_clock_now;
      return slot_reply(ST_NEW, victim);
    end

    if (hit < 0) begin
      r.status = ST_NOT_FOUND;
      return r;
    end
    if (op == OP_RELEASE) begin
      if (refs_of[hit] != '0) refs_of[hit] = refs_of[hit] - 1'b1;
      use_clock_now = use_clock_now + 1'b1;
      stamp_of[hit] = use_clock_now;
    end else if (op == OP_FORGET) begin
      tag_of[hit]   = '0;
      refs_of[hit]  = '0;
      gen_of[hit]   = '0;
      stamp_of[hit] = '0;
    end
    return slot_reply(ST_HIT, hit);
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : watch
    inode_reply_t want;
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        tag_of[i]   = '0;
        refs_of[i]  = '0;
        gen_of[i]   = '0;
        stamp_of[i] = '0;
      end
      gen_next      = GEN_W'(1);
      use_clock_now = '0;
      replies_due.delete();
    end else begin
      // A result seen at this edge always belongs to an earlier item than one
      // accepted at the same edge, so retire before predicting.
      if (out_valid === 1'b1) begin
        if (replies_due.size() == 0) begin
          $error("result with nothing expected: status %0d slot %0d",
                 out_status, out_slot_index);
          mismatches++;
        end else begin
          want = replies_due.pop_front();
          check_field("status", want.status, out_status);
          check_field("slot_index", want.slot, out_slot_index);
          check_field("ref_count", want.refs, out_ref_count);
          check_field("generation_out", want.gen, out_generation_out);
          check_field("use_stamp_out", want.stamp, out_use_stamp_out);
        end
      end
      if (start && !busy)
        replies_due.push_back(predict_reply(rlit_op_t'(in_op), in_inode_number));
    end
    fail_count <= mismatches;
    pending    <= replies_due.size();
  end

endmodule

// ----- tb/refcounted_lru_inode_table_unit_tb.sv -----
`timescale 1ns / 1ps

// Stimulus and verdict for the inode table. All prediction and comparison
// lives in the checker beside the block; this module only makes requests,
// watches for a hang and reports the outcome.
module refcounted_lru_inode_table_unit_tb
  import rlit_pkg::*;
  ();

  localparam int RANDOM_ITEMS   = 850;
  // The last items go in back to back, with no idle gaps at all.
  localparam int QUIET_TAIL     = 80;
  localparam int POOL_SIZE      = 96;
  // A request keeps the block busy through its sweep and decision; the longest
  // correct quiet spell is that plus an idle burst and the settling wait at the
  // end, so this limit leaves a wide margin.
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = SLOTS + 16;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [1:0]         in_op;
  logic [TAG_W-1:0]   in_inode_number;
  logic               out_valid;
  logic [2:0]         out_status;
  logic [SIDX_W-1:0]  out_slot_index;
  logic [REFS_W-1:0]  out_ref_count;
  logic [GEN_W-1:0]   out_generation_out;
  logic [STAMP_W-1:0] out_use_stamp_out;

  int fail_count;
  int pending;
  int idle_cycles = 0;

  // Tags that the random part draws from. Taking a short prefix keeps the
  // table lightly used; taking more than SLOTS forces evictions and full
  // table refusals.
  logic [TAG_W-1:0] tag_pool [POOL_SIZE];

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  refcounted_lru_inode_table_unit dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_op              (in_op),
    .in_inode_number    (in_inode_number),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_slot_index     (out_slot_index),
    .out_ref_count      (out_ref_count),
    .out_generation_out (out_generation_out),
    .out_use_stamp_out  (out_use_stamp_out)
  );

  inode_table_checker checker_i (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_op              (in_op),
    .in_inode_number    (in_inode_number),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_slot_index     (out_slot_index),
    .out_ref_count      (out_ref_count),
    .out_generation_out (out_generation_out),
    .out_use_stamp_out  (out_use_stamp_out),
    .fail_count         (fail_count),
    .pending            (pending)
  );

  // Presents one item and returns at the edge where the block takes it. Start
  // is left high, so a following call simply replaces the payload and the
  // next item follows without a gap.
  task automatic issue_request(input rlit_op_t op, input logic [TAG_W-1:0] ino);
    start           <= 1'b1;
    in_op           <= op;
    in_inode_number <= ino;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Drops start for a burst of cycles with rubbish on the payload. Sometimes
  // the burst is held back until the block has finished its scan, so that
  // gaps also land on the result cycle and on the idle block, not only early
  // in a scan.
  task automatic idle_input(input int cycles);
    start           <= 1'b0;
    in_op           <= rlit_op_t'($urandom_range(0, 3));
    in_inode_number <= $urandom();
    if ($urandom_range(0, 1) == 0) begin
      @(posedge clk);
      while (busy) @(posedge clk);
    end
    repeat (cycles) @(posedge clk);
  endtask

  // Operation mix per phase: filling, churning or draining the table.
  function automatic rlit_op_t pick_op(input int mode);
    int roll;
    roll = $urandom_range(0, 99);
    case (mode)
      0: begin
        if (roll < 75)      return OP_ACQUIRE;
        else if (roll < 85) return OP_RELEASE;
        else if (roll < 95) return OP_LOOKUP;
        else                return OP_FORGET;
      end
      1: begin
        if (roll < 40)      return OP_ACQUIRE;
        else if (roll < 75) return OP_RELEASE;
        else if (roll < 90) return OP_LOOKUP;
        else                return OP_FORGET;
      end
      default: begin
        if (roll < 15)      return OP_ACQUIRE;
        else if (roll < 70) return OP_RELEASE;
        else if (roll < 85) return OP_LOOKUP;
        else                return OP_FORGET;
      end
    endcase
  endfunction

  // Hang detection: any cycle in which neither an item is taken nor a result
  // is shown counts towards the limit.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid === 1'b1) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("[refcounted_lru_inode_table_unit] ERROR");
          $finish;
        end
      end
    end
  end

  initial begin : stimulus
    int               done_items;
    int               phase_len;
    int               pool_n;
    int               mode;
    int               roll;
    bit               quiet;
    rlit_op_t         op;
    logic [TAG_W-1:0] ino;

    rst_n           <= 1'b0;
    start           <= 1'b0;
    in_op           <= OP_LOOKUP;
    in_inode_number <= '0;

    // The pool opens with the extreme tags; the rest are random and nonzero.
    tag_pool[0] = 32'hFFFF_FFFF;
    tag_pool[1] = 32'h0000_0001;
    tag_pool[2] = 32'h8000_0000;
    tag_pool[3] = 32'h7FFF_FFFF;
    for (int i = 4; i < POOL_SIZE; i++) begin
      do tag_pool[i] = $urandom(); while (tag_pool[i] == '0);
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part. A zero tag is refused whatever the operation.
    issue_request(OP_LOOKUP, '0);
    issue_request(OP_ACQUIRE, '0);
    issue_request(OP_RELEASE, '0);
    issue_request(OP_FORGET, '0);
    // Every non-acquire operation misses on an empty table.
    issue_request(OP_LOOKUP, 32'hFFFF_FFFF);
    issue_request(OP_RELEASE, 32'hFFFF_FFFF);
    issue_request(OP_FORGET, 32'hFFFF_FFFF);
    // Allocate, hit, then release past zero to see the count hold at the floor.
    issue_request(OP_ACQUIRE, 32'hFFFF_FFFF);
    issue_request(OP_ACQUIRE, 32'hFFFF_FFFF);
    issue_request(OP_LOOKUP, 32'hFFFF_FFFF);
    issue_request(OP_RELEASE, 32'hFFFF_FFFF);
    issue_request(OP_RELEASE, 32'hFFFF_FFFF);
    issue_request(OP_RELEASE, 32'hFFFF_FFFF);
    // Forgetting a slot frees it, and the next allocation reuses that first
    // empty slot ahead of any higher one.
    issue_request(OP_ACQUIRE, 32'h0000_0001);
    issue_request(OP_ACQUIRE, 32'h8000_0000);
    issue_request(OP_FORGET, 32'h0000_0001);
    issue_request(OP_LOOKUP, 32'h0000_0001);
    issue_request(OP_ACQUIRE, 32'h7FFF_FFFF);
    issue_request(OP_FORGET, 32'hFFFF_FFFF);
    issue_request(OP_RELEASE, 32'hFFFF_FFFF);
    issue_request(OP_ACQUIRE, 32'hFFFF_FFFF);
    issue_request(OP_LOOKUP, '0);

    // Random part, in phases that each pick a pool size, an operation mix and
    // whether to idle at all. A little noise is mixed in: zero tags and fresh
    // tags that almost certainly miss.
    done_items = 0;
    while (done_items < RANDOM_ITEMS) begin
      phase_len = $urandom_range(30, 110);
      case ($urandom_range(0, 4))
        0:       pool_n = 6;
        1:       pool_n = 24;
        2:       pool_n = SLOTS;
        3:       pool_n = SLOTS + 6;
        default: pool_n = POOL_SIZE;
      endcase
      mode  = $urandom_range(0, 2);
      quiet = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < phase_len && done_items < RANDOM_ITEMS; k++) begin
        op   = pick_op(mode);
        roll = $urandom_range(0, 99);
        if (roll < 3)      ino = '0;
        else if (roll < 6) ino = $urandom();
        else               ino = tag_pool[$urandom_range(0, pool_n - 1)];
        if (!quiet && done_items < RANDOM_ITEMS - QUIET_TAIL &&
            $urandom_range(0, 3) == 0)
          idle_input($urandom_range(1, 10));
        issue_request(op, ino);
        done_items++;
      end
    end
    start <= 1'b0;

    // Let every outstanding result arrive, then give any stray one time to show.
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (fail_count == 0 && pending == 0)
      $display("[refcounted_lru_inode_table_unit] OK");
    else
      $display("[refcounted_lru_inode_table_unit] ERROR");
    $finish;
  end

endmodule

// ----- refcounted_lru_inode_table_unit.f -----
hw/rtl/rlit_pkg.sv
hw/rtl/rlit_ram.sv
hw/rtl/rlit_scan.sv
hw/rtl/refcounted_lru_inode_table_unit.sv
tb/inode_table_checker.sv
tb/refcounted_lru_inode_table_unit_tb.sv
